[src/xs128_pkg.sv]
// xs128_pkg: shared types and constants for the xorshift128 random source
// used by xs128_ctrl, xs128_datapath and xorshift128_random_source

package xs128_pkg;

    localparam int WORD_W  = 32;
    localparam int SEED_W  = 64;
    localparam int VALUE_W = 33;
    localparam int PCT_W   = 8;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_SEED    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RAW     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BOUNDED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CHANCE  = 2'd3;

    localparam logic [SEED_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [SEED_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [SEED_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
    localparam logic [VALUE_W-1:0] CHANCE_BASE = 33'd100;

    // floor(x / 100) = (x * CHANCE_RECIP) >> CHANCE_SHIFT for any 32-bit x
    localparam logic [WORD_W-1:0] CHANCE_RECIP = 32'h51EB_851F;
    localparam int                CHANCE_SHIFT = 37;

    localparam int DIV_STEPS  = WORD_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int NUM_WORDS  = 4;
    localparam int WIDX_W     = $clog2(NUM_WORDS);

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              seed_add;
        logic              mul_en;
        logic [1:0]        mul_phase;
        logic              mul_sel_b;
        logic [WIDX_W-1:0] word_idx;
        logic              seed_fix;
        logic              advance;
        logic              div_step;
        logic              chance_mul;
        logic              chance_sub;
        logic              emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              out_busy;
    } stat_t;

endpackage

[src/xorshift128_random_source.sv]
// xorshift128_random_source: top level of the xorshift128 random source
// depends on xs128_pkg, xs128_ctrl and xs128_datapath

// One request at a time: s_ready is high only while the block is idle, and a finished
// result waits in the output register so the next request can be taken meanwhile.
// Seeding runs four splitmix64 rounds, each 64-bit multiply being three 32x32
// partial products through one shared multiplier. A bounded draw runs a 32-step
// restoring remainder loop, one dividend bit per cycle; a chance draw does a
// reciprocal multiply for the quotient by 100, then a subtract; a bounded draw with
// high_bound <= low_bound goes straight to the result. Reset puts the generator at
// word 0 = 1, other words 0.

module xorshift128_random_source (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [xs128_pkg::KIND_W-1:0]         s_kind,
    input  logic [xs128_pkg::SEED_W-1:0]         s_seed_value,
    input  logic signed [xs128_pkg::WORD_W-1:0]  s_low_bound,
    input  logic signed [xs128_pkg::WORD_W-1:0]  s_high_bound,
    input  logic signed [xs128_pkg::PCT_W-1:0]   s_percent,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [xs128_pkg::VALUE_W-1:0] m_value,
    output logic                                 m_hit
);
    import xs128_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    xs128_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    xs128_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_kind       (s_kind),
        .s_seed_value (s_seed_value),
        .s_low_bound  (s_low_bound),
        .s_high_bound (s_high_bound),
        .s_percent    (s_percent),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_hit        (m_hit)
    );

endmodule

[src/xs128_datapath.sv]
// xs128_datapath: generator words, splitmix64 mixer with a shared 32x32 multiplier,
// restoring remainder unit, reciprocal modulo-100 unit and result register
// depends on xs128_pkg

module xs128_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  xs128_pkg::cmd_t                   cmd,
    output xs128_pkg::stat_t                  stat,
    input  logic [xs128_pkg::KIND_W-1:0]      s_kind,
    input  logic [xs128_pkg::SEED_W-1:0]      s_seed_value,
    input  logic signed [xs128_pkg::WORD_W-1:0] s_low_bound,
    input  logic signed [xs128_pkg::WORD_W-1:0] s_high_bound,
    input  logic signed [xs128_pkg::PCT_W-1:0]  s_percent,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [xs128_pkg::VALUE_W-1:0] m_value,
    output logic                              m_hit
);
    import xs128_pkg::*;

    logic [KIND_W-1:0]        kind_reg;
    logic signed [WORD_W-1:0] lo_reg;
    logic signed [PCT_W-1:0]  pct_reg;
    logic                     empty_reg;
    logic [VALUE_W-1:0]       div_reg;
    logic [VALUE_W-1:0]       rem_reg;
    logic [WORD_W-1:0]        draw_reg;
    logic [WORD_W-1:0]        quot_reg;
    logic [SEED_W-1:0]        acc_reg;
    logic [SEED_W-1:0]        z_reg;
    logic [SEED_W-1:0]        mul_reg;
    logic [SEED_W-1:0]        prod_reg;
    logic [WORD_W-1:0]        words_reg [NUM_WORDS];
    logic                     m_valid_reg;
    logic signed [VALUE_W-1:0] m_value_reg;
    logic                     m_hit_reg;

    logic [VALUE_W-1:0]       span;
    logic                     in_empty;
    logic [SEED_W-1:0]        acc_next;
    logic [SEED_W-1:0]        mul_const;
    logic [WORD_W-1:0]        mul_a;
    logic [WORD_W-1:0]        mul_b;
    logic [SEED_W-1:0]        mul_full;
    logic [SEED_W-1:0]        prod_fin;
    logic [WORD_W-1:0]        adv_t;
    logic [WORD_W-1:0]        adv_word;
    logic [VALUE_W:0]         div_trial;
    logic [VALUE_W-1:0]       rem_next;
    logic [SEED_W-1:0]        recip_prod;
    logic [WORD_W-1:0]        chance_rem;
    logic signed [VALUE_W-1:0] lo_ext;
    logic signed [VALUE_W-1:0] value_next;
    logic                     hit_next;

    // request decode
    assign span     = VALUE_W'({s_high_bound[WORD_W-1], s_high_bound}
                    - {s_low_bound[WORD_W-1], s_low_bound} + 33'd1);
    assign in_empty = (s_high_bound <= s_low_bound);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= s_kind;
            lo_reg    <= s_low_bound;
            pct_reg   <= s_percent;
            empty_reg <= in_empty;
            div_reg   <= span;
        end
    end

    // splitmix64 rounds
    assign acc_next  = acc_reg + GOLDEN_STEP;
    assign mul_const = cmd.mul_sel_b ? MIX_MUL_B : MIX_MUL_A;
    assign mul_a     = (cmd.mul_phase == 2'd2) ? z_reg[SEED_W-1:WORD_W] : z_reg[WORD_W-1:0];
    assign mul_b     = (cmd.mul_phase == 2'd1) ? mul_const[SEED_W-1:WORD_W]
                                               : mul_const[WORD_W-1:0];
    assign mul_full  = SEED_W'(mul_a) * SEED_W'(mul_b);
    assign prod_fin  = {prod_reg[SEED_W-1:WORD_W] + mul_reg[WORD_W-1:0],
                        prod_reg[WORD_W-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            acc_reg <= s_seed_value;
        end else if (cmd.seed_add) begin
            acc_reg <= acc_next;
        end
        if (cmd.seed_add) begin
            z_reg <= acc_next ^ (acc_next >> 30);
        end else if (cmd.mul_en && cmd.mul_phase == 2'd3 && !cmd.mul_sel_b) begin
            z_reg <= prod_fin ^ (prod_fin >> 27);
        end
        if (cmd.mul_en) begin
            mul_reg <= mul_full;
            if (cmd.mul_phase == 2'd1) begin
                prod_reg <= mul_reg;
            end else if (cmd.mul_phase == 2'd2) begin
                prod_reg <= prod_fin;
            end
        end
    end

    // xorshift128 step
    always_comb begin
        adv_t    = words_reg[3];
        adv_t    = adv_t ^ (adv_t << 11);
        adv_t    = adv_t ^ (adv_t >> 8);
        adv_word = adv_t ^ words_reg[0] ^ (words_reg[0] >> 19);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg[0] <= WORD_W'(1);
            words_reg[1] <= '0;
            words_reg[2] <= '0;
            words_reg[3] <= '0;
        end else if (cmd.advance) begin
            words_reg[3] <= words_reg[2];
            words_reg[2] <= words_reg[1];
            words_reg[1] <= words_reg[0];
            words_reg[0] <= adv_word;
        end else if (cmd.mul_en && cmd.mul_phase == 2'd3 && cmd.mul_sel_b) begin
            words_reg[cmd.word_idx] <= prod_fin[WORD_W-1:0] ^ prod_fin[SEED_W-2:WORD_W-1];
        end else if (cmd.seed_fix) begin
            if ((words_reg[0] | words_reg[1] | words_reg[2] | words_reg[3]) == '0) begin
                words_reg[0] <= WORD_W'(1);
            end
        end
    end

    // restoring remainder, one dividend bit per cycle
    assign div_trial = {rem_reg, draw_reg[WORD_W-1]};
    assign rem_next  = (div_trial >= {1'b0, div_reg})
                     ? VALUE_W'(div_trial - {1'b0, div_reg})
                     : div_trial[VALUE_W-1:0];

    // chance draw modulo 100 by reciprocal multiplication
    assign recip_prod = SEED_W'(draw_reg) * SEED_W'(CHANCE_RECIP);
    assign chance_rem = draw_reg - quot_reg * WORD_W'(CHANCE_BASE);

    always_ff @(posedge aclk) begin
        if (cmd.chance_mul) begin
            quot_reg <= WORD_W'(recip_prod >> CHANCE_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.advance) begin
            draw_reg <= adv_word;
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            draw_reg <= draw_reg << 1;
            rem_reg  <= rem_next;
        end else if (cmd.chance_sub) begin
            rem_reg  <= VALUE_W'(chance_rem);
        end
    end

    // result select
    assign lo_ext = VALUE_W'(lo_reg);

    always_comb begin
        value_next = '0;
        hit_next   = 1'b0;
        case (kind_reg)
            KIND_SEED: begin
                value_next = '0;
            end
            KIND_RAW: begin
                value_next = $signed({1'b0, draw_reg});
            end
            KIND_BOUNDED: begin
                value_next = empty_reg ? lo_ext : lo_ext + $signed(rem_reg);
            end
            default: begin
                value_next = $signed(rem_reg);
                hit_next   = ($signed({1'b0, rem_reg[6:0]}) < pct_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_value_reg <= value_next;
            m_hit_reg   <= hit_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_hit   = m_hit_reg;

    assign stat.kind     = kind_reg;
    assign stat.empty    = empty_reg;
    assign stat.out_busy = m_valid_reg && !m_ready;

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |=> (rem_reg < div_reg))
        else $error("remainder not below divisor");

    a_chance_below_base: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.chance_sub |=> (rem_reg < CHANCE_BASE))
        else $error("chance draw not reduced below 100");

    a_seed_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.seed_fix |=> ((words_reg[0] | words_reg[1] | words_reg[2] | words_reg[3]) != '0))
        else $error("generator state all zero after seeding");

endmodule

[src/xs128_ctrl.sv]
// xs128_ctrl: sequencer for seeding, drawing and remainder steps
// depends on xs128_pkg

module xs128_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  xs128_pkg::stat_t  stat,
    output xs128_pkg::cmd_t   cmd
);
    import xs128_pkg::*;

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_DISPATCH   = 4'd1;
    localparam logic [3:0] ST_SEED_ADD   = 4'd2;
    localparam logic [3:0] ST_MUL        = 4'd3;
    localparam logic [3:0] ST_SEED_FIX   = 4'd4;
    localparam logic [3:0] ST_ADVANCE    = 4'd5;
    localparam logic [3:0] ST_DIV        = 4'd6;
    localparam logic [3:0] ST_EMIT       = 4'd7;
    localparam logic [3:0] ST_CHANCE_MUL = 4'd8;
    localparam logic [3:0] ST_CHANCE_SUB = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic              sel_b_reg, sel_b_next;
    logic [WIDX_W-1:0] round_reg, round_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        sel_b_next = sel_b_reg;
        round_next = round_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.mul_phase = phase_reg;
        cmd.mul_sel_b = sel_b_reg;
        cmd.word_idx  = round_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (stat.kind)
                    KIND_SEED: begin
                        round_next = '0;
                        state_next = ST_SEED_ADD;
                    end
                    KIND_RAW: begin
                        state_next = ST_ADVANCE;
                    end
                    KIND_BOUNDED: begin
                        state_next = stat.empty ? ST_EMIT : ST_ADVANCE;
                    end
                    default: begin
                        state_next = ST_ADVANCE;
                    end
                endcase
            end
            ST_SEED_ADD: begin
                cmd.seed_add = 1'b1;
                phase_next   = 2'd0;
                sel_b_next   = 1'b0;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                if (phase_reg == 2'd3) begin
                    phase_next = 2'd0;
                    if (!sel_b_reg) begin
                        sel_b_next = 1'b1;
                    end else if (round_reg == WIDX_W'(NUM_WORDS - 1)) begin
                        state_next = ST_SEED_FIX;
                    end else begin
                        round_next = round_reg + 1'b1;
                        state_next = ST_SEED_ADD;
                    end
                end else begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            ST_SEED_FIX: begin
                cmd.seed_fix = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_ADVANCE: begin
                cmd.advance = 1'b1;
                step_next   = '0;
                state_next  = (stat.kind == KIND_RAW)    ? ST_EMIT :
                              (stat.kind == KIND_CHANCE) ? ST_CHANCE_MUL : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_CHANCE_MUL: begin
                cmd.chance_mul = 1'b1;
                state_next     = ST_CHANCE_SUB;
            end
            ST_CHANCE_SUB: begin
                cmd.chance_sub = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            sel_b_reg <= 1'b0;
            round_reg <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            sel_b_reg <= sel_b_next;
            round_reg <= round_next;
            step_reg  <= step_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.seed_add || cmd.mul_en || cmd.advance || cmd.div_step || cmd.emit))
        else $error("datapath command issued while idle");

    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_ready)
        else $error("new request taken before the previous one finished");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && step_reg == STEP_W'(DIV_STEPS - 1)) |=> (state_reg == ST_EMIT))
        else $error("remainder loop did not end after the last step");

    a_seed_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.seed_fix |-> $past(cmd.mul_en && cmd.mul_sel_b && cmd.mul_phase == 2'd3))
        else $error("seed fixup without a finished last round");

endmodule
